// ===== design/mavg_pkg.sv =====
package mavg_pkg;

  // Defaults for the top-level parameters.
  localparam int MAVG_MAX_WINDOW   = 64;
  localparam int MAVG_SAMPLE_WIDTH = 16;

  // Window length register.
  localparam int             WIN_W     = 7;
  localparam logic [WIN_W-1:0] WIN_RESET = 7'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_EMIT
  } mavg_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // latch the sample and read the oldest history entry
    logic update;    // form the total, update sum and history, start the divider
    logic div_step;  // one quotient bit
    logic emit;      // load the output register
  } mavg_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_last;  // the current divider step is the final one
    logic out_full;  // the output register holds a beat that is not taken this cycle
  } mavg_sts_t;

endpackage

// ===== design/mavg_ctrl.sv =====
module mavg_ctrl
  import mavg_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  mavg_sts_t sts,
  output mavg_cmd_t cmd
);

  mavg_state_t state;
  mavg_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.update = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // Wait until the output register can take the new beat.
        if (!sts.out_full) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/mavg_div.sv =====
module mavg_div
  import mavg_pkg::*;
#(
  parameter int DIVIDEND_W = 22,
  parameter int DIVISOR_W  = WIN_W
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  step,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic [DIVIDEND_W-1:0] quotient,
  output logic                  last
);

  localparam int CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

  logic [DIVIDEND_W-1:0] dq;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dvs;
  logic [CNT_W-1:0]      cnt;
  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W:0]    trial;

  // Restoring division, one quotient bit per step. The dividend register
  // shifts out its top bit and takes the quotient bit in at the bottom.
  assign shifted  = {rem, dq[DIVIDEND_W-1]};
  assign trial    = shifted - {1'b0, dvs};
  assign last     = (cnt == '0);
  assign quotient = dq;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(DIVIDEND_W - 1);
    end else if (step && !last) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (step) begin
      if (!trial[DIVISOR_W]) begin
        rem <= trial[DIVISOR_W-1:0];
        dq  <= {dq[DIVIDEND_W-2:0], 1'b1};
      end else begin
        rem <= shifted[DIVISOR_W-1:0];
        dq  <= {dq[DIVIDEND_W-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== design/mavg_dp.sv =====
module mavg_dp
  import mavg_pkg::*;
#(
  parameter int MAX_WINDOW   = MAVG_MAX_WINDOW,
  parameter int SAMPLE_WIDTH = MAVG_SAMPLE_WIDTH,
  parameter int TDATA_W      = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [TDATA_W-1:0] s_tdata,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,
  input  logic               cfg_valid,
  input  logic [WIN_W-1:0]   cfg_data,
  input  mavg_cmd_t          cmd,
  output mavg_sts_t          sts
);

  localparam int SUM_W = SAMPLE_WIDTH + $clog2(MAX_WINDOW);
  localparam int DEPTH = MAX_WINDOW - 1;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMP_W = ((PTR_W > WIN_W) ? PTR_W : WIN_W) + 1;

  logic [SAMPLE_WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0]        hvalid;

  logic [WIN_W-1:0]        win;
  logic [WIN_W-1:0]        eff_len;
  logic [WIN_W-1:0]        span;
  logic [PTR_W-1:0]        ptr;
  logic [PTR_W-1:0]        rd_ptr;
  logic [PTR_W-1:0]        rd_ptr_q;
  logic [CMP_W-1:0]        ptr_inc;
  logic [PTR_W-1:0]        ptr_next;
  logic signed [SUM_W-1:0] running_sum;
  logic signed [SUM_W-1:0] total;
  logic signed [SUM_W-1:0] oldest;
  logic [SUM_W-1:0]        magnitude;
  logic [SAMPLE_WIDTH-1:0] sample_q;
  logic [SAMPLE_WIDTH-1:0] rd_data;
  logic                    rd_valid;
  logic                    neg;
  logic [SUM_W-1:0]        quotient;
  logic [SUM_W-1:0]        signed_q;
  logic                    div_last;

  // Zero acts as a window of one, anything past MAX_WINDOW saturates to MAX_WINDOW.
  always_comb begin
    if (win == '0) begin
      eff_len = WIN_W'(1);
    end else if (int'(win) > MAX_WINDOW) begin
      eff_len = WIN_W'(MAX_WINDOW);
    end else begin
      eff_len = win;
    end
  end

  assign span   = eff_len - 1'b1;
  assign rd_ptr = (CMP_W'(ptr) >= CMP_W'(span)) ? '0 : ptr;

  assign ptr_inc  = CMP_W'(rd_ptr_q) + 1'b1;
  assign ptr_next = (ptr_inc >= CMP_W'(span)) ? '0 : ptr_inc[PTR_W-1:0];

  assign oldest    = rd_valid ? SUM_W'(signed'(rd_data)) : '0;
  assign total     = running_sum + SUM_W'(signed'(sample_q));
  assign magnitude = total[SUM_W-1] ? SUM_W'(-total) : total;

  assign signed_q = neg ? (~quotient + 1'b1) : quotient;

  // History storage: read in the capture cycle, written in the update cycle.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rd_data <= mem[rd_ptr];
    end
    if (cmd.update && (eff_len > WIN_W'(1))) begin
      mem[rd_ptr_q] <= sample_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample_q <= s_tdata[SAMPLE_WIDTH-1:0];
      rd_ptr_q <= rd_ptr;
      rd_valid <= hvalid[rd_ptr];
    end
    if (cmd.update) begin
      neg <= total[SUM_W-1];
    end
  end

  // Window register, running sum, pointer and entry valid bits. A write of
  // the window length empties the history just as reset does.
  always_ff @(posedge clk) begin
    if (rst) begin
      win         <= WIN_RESET;
      hvalid      <= '0;
      running_sum <= '0;
      ptr         <= '0;
    end else if (cfg_valid) begin
      win         <= cfg_data;
      hvalid      <= '0;
      running_sum <= '0;
      ptr         <= '0;
    end else if (cmd.update && (eff_len > WIN_W'(1))) begin
      running_sum      <= total - oldest;
      hvalid[rd_ptr_q] <= 1'b1;
      ptr              <= ptr_next;
    end
  end

  mavg_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (WIN_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.update),
    .step     (cmd.div_step),
    .dividend (magnitude),
    .divisor  (eff_len),
    .quotient (quotient),
    .last     (div_last)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= TDATA_W'(signed_q[SAMPLE_WIDTH-1:0]);
    end
  end

  assign sts.div_last = div_last;
  assign sts.out_full = m_tvalid && !m_tready;

endmodule

// ===== design/moving_average_filter_unit.sv =====
// Moving average (boxcar) filter.
//
// Samples arrive on the s_ stream, one signed sample per beat. For every
// accepted beat one beat leaves on the m_ stream carrying the mean of that
// sample and the previous window_length-1 samples, truncated toward zero.
// History that has not been filled yet counts as zero.
// The window length is written through the cfg_ channel, which is always
// ready. Write it only while the filter is idle. A write empties the history
// and the running sum. A length of zero acts as one; a length above
// MAX_WINDOW saturates to MAX_WINDOW. A window of one passes samples through.
// Processing: after a sample is accepted, the oldest history entry is read,
// then the running sum is updated and the divider started, and the
// restoring divider then produces one quotient bit per cycle for every bit
// of the sum (SAMPLE_WIDTH + clog2(MAX_WINDOW) bits, 22 at the defaults).
// m_tvalid rises once the quotient is loaded into the output register, and
// no new sample is taken before the current one has been emitted.
// The result sits in an output register. If the receiver stalls, the filter
// finishes the next average and then waits until the held beat is taken.
// Reset (synchronous, active high) sets the window length to 4 and clears the
// history, the sum and m_tvalid.
module moving_average_filter_unit
  import mavg_pkg::*;
#(
  parameter int MAX_WINDOW   = MAVG_MAX_WINDOW,
  parameter int SAMPLE_WIDTH = MAVG_SAMPLE_WIDTH,
  parameter int TDATA_W      = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [TDATA_W-1:0] s_tdata,    // sample, zero padded to whole bytes
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,    // mean, zero padded to whole bytes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [WIN_W-1:0]   cfg_data    // window_length
);

  mavg_cmd_t cmd;
  mavg_sts_t sts;

  // Configuration is taken in any cycle.
  assign cfg_ready = 1'b1;

  mavg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mavg_dp #(
    .MAX_WINDOW   (MAX_WINDOW),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .TDATA_W      (TDATA_W)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
